// File: hw/rtl/source_text_tokenizer_top_assert.svh
// Assertion macros shared by the tokenizer top level.
`ifndef SOURCE_TEXT_TOKENIZER_TOP_ASSERT_SVH
`define SOURCE_TEXT_TOKENIZER_TOP_ASSERT_SVH

// Condition in the same cycle.
`define STT_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Condition in the following cycle.
`define STT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/stt_pkg.sv
package stt_pkg;

	// Queue depths (powers of two).
	localparam int CLS_DEPTH = 2;
	localparam int OUT_DEPTH = 4;

	// Keyword table geometry.
	localparam int KW_NUM   = 8;
	localparam int KW_CHARS = 6;

	// Token kinds.
	localparam logic [4:0] KIND_LBRACE  = 5'd0;
	localparam logic [4:0] KIND_RBRACE  = 5'd1;
	localparam logic [4:0] KIND_DOT     = 5'd2;
	localparam logic [4:0] KIND_LPAREN  = 5'd3;
	localparam logic [4:0] KIND_RPAREN  = 5'd4;
	localparam logic [4:0] KIND_COMMA   = 5'd5;
	localparam logic [4:0] KIND_AMP     = 5'd6;
	localparam logic [4:0] KIND_SLASH   = 5'd7;
	localparam logic [4:0] KIND_MINUS   = 5'd8;
	localparam logic [4:0] KIND_PLUS    = 5'd9;
	localparam logic [4:0] KIND_STAR    = 5'd10;
	localparam logic [4:0] KIND_GT      = 5'd11;
	localparam logic [4:0] KIND_LT      = 5'd13;
	localparam logic [4:0] KIND_ASSIGN  = 5'd15;
	localparam logic [4:0] KIND_SEMI    = 5'd17;
	localparam logic [4:0] KIND_INT_LIT = 5'd18;
	localparam logic [4:0] KIND_IDENT   = 5'd19;
	localparam logic [4:0] KIND_KW_BASE = 5'd20;
	localparam logic [4:0] KIND_UNKNOWN = 5'd28;

	// Configuration register index.
	localparam logic REG_FILE_TAG = 1'b0;

	// Byte classes produced by the front end.
	typedef enum logic [2:0] {
		CLS_SKIP    = 3'd0,
		CLS_NEWLINE = 3'd1,
		CLS_PUNCT   = 3'd2,
		CLS_OPER    = 3'd3,
		CLS_DIGIT   = 3'd4,
		CLS_ALPHA   = 3'd5,
		CLS_UNKNOWN = 3'd6
	} cls_kind_t;

	// Operators that may take a trailing '='.
	typedef enum logic [1:0] {
		OP_NONE = 2'd0,
		OP_GT   = 2'd1,
		OP_LT   = 2'd2,
		OP_EQ   = 2'd3
	} op_t;

	typedef struct packed {
		cls_kind_t  cls;
		op_t        op;
		logic [4:0] kind;
		logic [7:0] text_byte;
		logic       first;
		logic       last;
	} cls_item_t;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       first_of_text;
		logic       last_of_text;
	} stt_item_t;

	typedef struct packed {
		logic [4:0]  token_kind;
		logic [23:0] start_offset;
		logic [15:0] token_length;
		logic [23:0] line_number;
		logic [23:0] column_number;
		logic [15:0] token_file;
		logic        last_of_run;
	} stt_result_t;

	// Scanner status seen by the top level.
	typedef struct packed {
		logic take;
		logic busy;
	} scan_stat_t;

	localparam logic [7:0] KW_TEXT [KW_NUM][KW_CHARS] = '{
		'{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"i", "n", "t", 8'h00, 8'h00, 8'h00},
		'{"f", "o", "r", 8'h00, 8'h00, 8'h00},
		'{"e", "l", "s", "e", 8'h00, 8'h00},
		'{"c", "h", "a", "r", 8'h00, 8'h00},
		'{"b", "r", "e", "a", "k", 8'h00},
		'{"s", "t", "r", "u", "c", "t"},
		'{"r", "e", "t", "u", "r", "n"}
	};

	localparam logic [2:0] KW_LEN [KW_NUM] = '{
		3'd2, 3'd3, 3'd3, 3'd4, 3'd4, 3'd5, 3'd6, 3'd6
	};

	// Kind of a word from its leading characters and its length code
	// (a code of 7 stands for any length over KW_CHARS, which no keyword has).
	function automatic logic [4:0] kw_kind(input logic [KW_CHARS-1:0][7:0] pre,
			input logic [2:0] n);
		logic [4:0] kind;
		logic       same;
		kind = KIND_IDENT;
		for (int k = KW_NUM - 1; k >= 0; k--) begin
			same = (n == KW_LEN[k]);
			for (int j = 0; j < KW_CHARS; j++) begin
				if ((3'(j) < KW_LEN[k]) && (pre[j] != KW_TEXT[k][j])) begin
					same = 1'b0;
				end
			end
			if (same) begin
				kind = KIND_KW_BASE + 5'(k);
			end
		end
		return kind;
	endfunction

	// Kind of a lone relational or assignment operator.
	function automatic logic [4:0] op_kind(input op_t op);
		logic [4:0] kind;
		case (op)
			OP_GT:   kind = KIND_GT;
			OP_LT:   kind = KIND_LT;
			default: kind = KIND_ASSIGN;
		endcase
		return kind;
	endfunction

endpackage

// File: hw/rtl/source_text_tokenizer_top.sv
// Channel   Handshake            Payload        Transaction
// input     push / full          item           one byte of source text
// result    pop / empty          result         one token
// config    psel/penable/pwrite  paddr, pwdata  one register write or read
//
// One byte is taken per cycle unless full; the scanner takes one per cycle given room.
// A byte causes up to two tokens, and tokens leave one per cycle through the
// four-entry output queue, so runs of two-token bytes go at the pop rate.
// A completing byte passes the byte queue; its token is registered in the output queue.
// arst_n clears the queues, the position counters, the scanner and file_tag.
// The scanner stalls while the output queue holds more than two tokens.
module source_text_tokenizer_top import stt_pkg::*; #(
	parameter int OFFSET_BITS   = 24,
	parameter int LENGTH_BITS   = 16,
	parameter int KEYWORD_CHARS = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  stt_item_t   item,
	output logic        full,
	input  logic        pop,
	output logic        empty,
	output stt_result_t result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [15:0]            file_tag_q;
	logic                   head_valid, room;
	cls_item_t              head;
	logic [OFFSET_BITS-1:0] head_pos, head_col, head_line;
	logic [1:0]             wr_n;
	stt_result_t            tok0, tok1;
	scan_stat_t             stat;

	// Configuration register.
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_FILE_TAG) ? {16'd0, file_tag_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			file_tag_q <= '0;
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_FILE_TAG)) begin
			file_tag_q <= pwdata[15:0];
		end
	end

	// Front end: classification, positions and the byte queue.
	stt_front #(
		.OFFSET_BITS(OFFSET_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.item      (item),
		.full      (full),
		.take      (stat.take),
		.head_valid(head_valid),
		.head      (head),
		.head_pos  (head_pos),
		.head_col  (head_col),
		.head_line (head_line)
	);

	// Back end: token scanner.
	stt_scan #(
		.OFFSET_BITS  (OFFSET_BITS),
		.LENGTH_BITS  (LENGTH_BITS),
		.KEYWORD_CHARS(KEYWORD_CHARS)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head      (head),
		.head_pos  (head_pos),
		.head_col  (head_col),
		.head_line (head_line),
		.file_tag  (file_tag_q),
		.room      (room),
		.wr_n      (wr_n),
		.tok0      (tok0),
		.tok1      (tok1),
		.stat      (stat)
	);

	// Result queue.
	stt_outq u_outq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_n    (wr_n),
		.wr_data0(tok0),
		.wr_data1(tok1),
		.pop     (pop),
		.empty   (empty),
		.result  (result),
		.room    (room)
	);

`include "source_text_tokenizer_top_assert.svh"

	// A full byte queue always offers a byte to the scanner.
	`STT_ASSERT_IMPLY(a_full_has_head, full, head_valid, "byte queue full but empty")
	// An accepted byte is in the queue in the next cycle.
	`STT_ASSERT_NEXT(a_push_lands, push && !full, head_valid, "accepted byte lost")
	// End of text leaves no token open.
	`STT_ASSERT_NEXT(a_last_flushes, stat.take && head.last, !stat.busy,
		"token still open after end of text")
	// Tokens written by the scanner show up on the result port.
	`STT_ASSERT_NEXT(a_tokens_visible, wr_n != 2'd0, !empty, "written token not visible")

endmodule

// File: hw/rtl/stt_front.sv
module stt_front import stt_pkg::*; #(
	parameter int OFFSET_BITS = 24
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  stt_item_t              item,
	output logic                   full,
	input  logic                   take,
	output logic                   head_valid,
	output cls_item_t              head,
	output logic [OFFSET_BITS-1:0] head_pos,
	output logic [OFFSET_BITS-1:0] head_col,
	output logic [OFFSET_BITS-1:0] head_line
);

	localparam int PTR_W = $clog2(CLS_DEPTH);
	localparam int CNT_W = $clog2(CLS_DEPTH + 1);
	localparam logic [OFFSET_BITS-1:0] LINE_ONE = OFFSET_BITS'(1);
	localparam logic [OFFSET_BITS-1:0] LINE_MAX = '1;

	logic [OFFSET_BITS-1:0] pos_q, line_q, nl_q;
	logic [OFFSET_BITS-1:0] pos_b, line_b, nl_b, col_b;
	cls_item_t              cls_d;
	logic                   accept;

	cls_item_t              q_cls  [CLS_DEPTH];
	logic [OFFSET_BITS-1:0] q_pos  [CLS_DEPTH];
	logic [OFFSET_BITS-1:0] q_col  [CLS_DEPTH];
	logic [OFFSET_BITS-1:0] q_line [CLS_DEPTH];
	logic [PTR_W-1:0]       wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]       cnt_q;

	assign full       = (cnt_q == CNT_W'(CLS_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign accept     = push && !full;

	// Byte classification.
	always_comb begin
		cls_d.cls       = CLS_UNKNOWN;
		cls_d.op        = OP_NONE;
		cls_d.kind      = KIND_UNKNOWN;
		cls_d.text_byte = item.text_byte;
		cls_d.first     = item.first_of_text;
		cls_d.last      = item.last_of_text;
		case (item.text_byte)
			"\n": cls_d.cls = CLS_NEWLINE;
			" ":  cls_d.cls = CLS_SKIP;
			"{": begin cls_d.cls = CLS_PUNCT; cls_d.kind = KIND_LBRACE; end
			"}": begin cls_d.cls = CLS_PUNCT; cls_d.kind = KIND_RBRACE; end
			".": begin cls_d.cls = CLS_PUNCT; cls_d.kind = KIND_DOT; end
			"(": begin cls_d.cls = CLS_PUNCT; cls_d.kind = KIND_LPAREN; end
			")": begin cls_d.cls = CLS_PUNCT; cls_d.kind = KIND_RPAREN; end
			",": begin cls_d.cls = CLS_PUNCT; cls_d.kind = KIND_COMMA; end
			"&": begin cls_d.cls = CLS_PUNCT; cls_d.kind = KIND_AMP; end
			"/": begin cls_d.cls = CLS_PUNCT; cls_d.kind = KIND_SLASH; end
			"-": begin cls_d.cls = CLS_PUNCT; cls_d.kind = KIND_MINUS; end
			"+": begin cls_d.cls = CLS_PUNCT; cls_d.kind = KIND_PLUS; end
			"*": begin cls_d.cls = CLS_PUNCT; cls_d.kind = KIND_STAR; end
			";": begin cls_d.cls = CLS_PUNCT; cls_d.kind = KIND_SEMI; end
			">": begin cls_d.cls = CLS_OPER; cls_d.op = OP_GT; end
			"<": begin cls_d.cls = CLS_OPER; cls_d.op = OP_LT; end
			"=": begin cls_d.cls = CLS_OPER; cls_d.op = OP_EQ; end
			default: begin
				if ((item.text_byte >= "0") && (item.text_byte <= "9")) begin
					cls_d.cls = CLS_DIGIT;
				end else if (((item.text_byte >= "a") && (item.text_byte <= "z")) ||
						((item.text_byte >= "A") && (item.text_byte <= "Z"))) begin
					cls_d.cls = CLS_ALPHA;
				end
			end
		endcase
	end

	// Position, line and column of this byte; a new text restarts them.
	always_comb begin
		pos_b  = item.first_of_text ? '0 : pos_q;
		line_b = item.first_of_text ? LINE_ONE : line_q;
		nl_b   = item.first_of_text ? '0 : nl_q;
		col_b  = pos_b - nl_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			line_q <= LINE_ONE;
			nl_q   <= '0;
		end else if (accept) begin
			pos_q <= pos_b + LINE_ONE;
			if (cls_d.cls == CLS_NEWLINE) begin
				line_q <= (line_b == LINE_MAX) ? line_b : line_b + LINE_ONE;
				nl_q   <= pos_b;
			end else begin
				line_q <= line_b;
				nl_q   <= nl_b;
			end
		end
	end

	// Queue of classified bytes towards the scanner.
	always_ff @(posedge clk) begin
		if (accept) begin
			q_cls[wr_ptr_q]  <= cls_d;
			q_pos[wr_ptr_q]  <= pos_b;
			q_col[wr_ptr_q]  <= col_b;
			q_line[wr_ptr_q] <= line_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (accept) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (take) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			cnt_q <= cnt_q + CNT_W'(accept) - CNT_W'(take);
		end
	end

	assign head      = q_cls[rd_ptr_q];
	assign head_pos  = q_pos[rd_ptr_q];
	assign head_col  = q_col[rd_ptr_q];
	assign head_line = q_line[rd_ptr_q];

endmodule

// File: hw/rtl/stt_scan.sv
module stt_scan import stt_pkg::*; #(
	parameter int OFFSET_BITS   = 24,
	parameter int LENGTH_BITS   = 16,
	parameter int KEYWORD_CHARS = 6
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   head_valid,
	input  cls_item_t              head,
	input  logic [OFFSET_BITS-1:0] head_pos,
	input  logic [OFFSET_BITS-1:0] head_col,
	input  logic [OFFSET_BITS-1:0] head_line,
	input  logic [15:0]            file_tag,
	input  logic                   room,
	output logic [1:0]             wr_n,
	output stt_result_t            tok0,
	output stt_result_t            tok1,
	output scan_stat_t             stat
);

	localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;
	localparam logic [LENGTH_BITS-1:0] LEN_ONE = LENGTH_BITS'(1);
	localparam logic [LENGTH_BITS-1:0] LEN_TWO = LENGTH_BITS'(2);
	localparam logic [LENGTH_BITS-1:0] LEN_KW  = LENGTH_BITS'(KW_CHARS);

	typedef enum logic [3:0] {
		MODE_IDLE   = 4'b0001,
		MODE_NUMBER = 4'b0010,
		MODE_WORD   = 4'b0100,
		MODE_OPER   = 4'b1000
	} mode_t;

	mode_t                  mode_q, mode_m, mode_d;
	op_t                    pend_q, pend_d;
	logic [OFFSET_BITS-1:0] start_q, start_d, col_q, col_d;
	logic [LENGTH_BITS-1:0] len_q, len_d, len_inc;
	logic [7:0]             prefix_q [KEYWORD_CHARS];
	logic [7:0]             prefix_d [KEYWORD_CHARS];
	logic [KW_CHARS-1:0][7:0] pre_cur, pre_nxt;
	logic [2:0]             n_cur, n_nxt;
	logic                   take, consumed, a_v, f_v, l_v;
	stt_result_t            tok_a, tok_f, tok_l;
	logic [1:0]             n_tok;

	assign take = head_valid && room;

	function automatic stt_result_t make_tok(input logic [4:0] kind,
			input logic [OFFSET_BITS-1:0] start, input logic [LENGTH_BITS-1:0] len,
			input logic [OFFSET_BITS-1:0] line, input logic [OFFSET_BITS-1:0] col,
			input logic [15:0] tag);
		stt_result_t t;
		t.token_kind    = kind;
		t.start_offset  = 24'(start);
		t.token_length  = 16'(len);
		t.line_number   = 24'(line);
		t.column_number = 24'(col);
		t.token_file    = tag;
		t.last_of_run   = 1'b0;
		return t;
	endfunction

	// Keyword lookup inputs for the open word now and after this byte.
	always_comb begin
		for (int j = 0; j < KW_CHARS; j++) begin
			pre_cur[j] = prefix_q[j];
			pre_nxt[j] = prefix_d[j];
		end
		n_cur = (len_q <= LEN_KW) ? len_q[2:0] : 3'd7;
		n_nxt = (len_d <= LEN_KW) ? len_d[2:0] : 3'd7;
	end

	assign len_inc = (len_q == LEN_MAX) ? len_q : len_q + LEN_ONE;

	// Token scanner: close, continue or open a token for the head byte, or emit a one-byte token.
	always_comb begin
		mode_m   = head.first ? MODE_IDLE : mode_q;
		mode_d   = mode_m;
		pend_d   = head.first ? OP_NONE : pend_q;
		start_d  = start_q;
		col_d    = col_q;
		len_d    = len_q;
		prefix_d = prefix_q;
		consumed = 1'b0;
		a_v      = 1'b0;
		f_v      = 1'b0;
		tok_a    = make_tok(KIND_INT_LIT, start_q, len_q, head_line, col_q, file_tag);
		tok_f    = make_tok(head.kind, head_pos, LEN_ONE, head_line, head_col, file_tag);

		case (mode_m)
			MODE_NUMBER: begin
				if (head.cls == CLS_DIGIT) begin
					consumed = 1'b1;
					len_d    = len_inc;
				end else begin
					a_v    = 1'b1;
					mode_d = MODE_IDLE;
				end
			end
			MODE_WORD: begin
				if ((head.cls == CLS_DIGIT) || (head.cls == CLS_ALPHA)) begin
					consumed = 1'b1;
					for (int i = 0; i < KEYWORD_CHARS; i++) begin
						if (len_q == LENGTH_BITS'(i)) begin
							prefix_d[i] = head.text_byte;
						end
					end
					len_d = len_inc;
				end else begin
					a_v              = 1'b1;
					tok_a.token_kind = kw_kind(pre_cur, n_cur);
					mode_d           = MODE_IDLE;
				end
			end
			MODE_OPER: begin
				a_v    = 1'b1;
				mode_d = MODE_IDLE;
				if ((head.cls == CLS_OPER) && (head.op == OP_EQ)) begin
					consumed = 1'b1;
					tok_a    = make_tok(op_kind(pend_q) + 5'd1, start_q, LEN_TWO, head_line,
						col_q, file_tag);
				end else begin
					tok_a = make_tok(op_kind(pend_q), start_q, LEN_ONE, head_line, col_q,
						file_tag);
				end
			end
			default: begin
			end
		endcase

		// A byte that did not extend a token starts afresh.
		if (!consumed) begin
			case (head.cls)
				CLS_PUNCT: f_v = 1'b1;
				CLS_UNKNOWN: begin
					f_v              = 1'b1;
					tok_f.token_kind = KIND_UNKNOWN;
				end
				CLS_OPER: begin
					mode_d  = MODE_OPER;
					pend_d  = head.op;
					start_d = head_pos;
					col_d   = head_col;
					len_d   = LEN_ONE;
				end
				CLS_DIGIT: begin
					mode_d  = MODE_NUMBER;
					start_d = head_pos;
					col_d   = head_col;
					len_d   = LEN_ONE;
				end
				CLS_ALPHA: begin
					mode_d      = MODE_WORD;
					start_d     = head_pos;
					col_d       = head_col;
					len_d       = LEN_ONE;
					prefix_d[0] = head.text_byte;
				end
				default: begin
				end
			endcase
		end

		// End of text flushes whatever is still open.
		l_v   = head.last && (mode_d != MODE_IDLE);
		tok_l = make_tok(KIND_INT_LIT, start_d, len_d, head_line, col_d, file_tag);
		case (mode_d)
			MODE_WORD: tok_l.token_kind = kw_kind(pre_nxt, n_nxt);
			MODE_OPER: begin
				tok_l.token_kind   = op_kind(pend_d);
				tok_l.token_length = 16'(LEN_ONE);
			end
			default: begin
			end
		endcase
	end

	// Order the tokens of this byte and mark the final one.
	always_comb begin
		tok0  = tok_a;
		tok1  = tok_f;
		n_tok = 2'd0;
		if (a_v) begin
			if (f_v) begin
				n_tok = 2'd2;
			end else if (l_v) begin
				tok1  = tok_l;
				n_tok = 2'd2;
			end else begin
				n_tok = 2'd1;
			end
		end else if (f_v) begin
			tok0  = tok_f;
			n_tok = 2'd1;
		end else if (l_v) begin
			tok0  = tok_l;
			n_tok = 2'd1;
		end
		if (n_tok == 2'd1) begin
			tok0.last_of_run = 1'b1;
		end
		if (n_tok == 2'd2) begin
			tok1.last_of_run = 1'b1;
		end
		wr_n = take ? n_tok : 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			pend_q <= OP_NONE;
		end else if (take) begin
			mode_q <= l_v ? MODE_IDLE : mode_d;
			pend_q <= pend_d;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			start_q  <= start_d;
			col_q    <= col_d;
			len_q    <= len_d;
			prefix_q <= prefix_d;
		end
	end

	assign stat.take = take;
	assign stat.busy = (mode_q != MODE_IDLE);

endmodule

// File: hw/rtl/stt_outq.sv
module stt_outq import stt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [1:0]  wr_n,
	input  stt_result_t wr_data0,
	input  stt_result_t wr_data1,
	input  logic        pop,
	output logic        empty,
	output stt_result_t result,
	output logic        room
);

	localparam int PTR_W = $clog2(OUT_DEPTH);
	localparam int CNT_W = $clog2(OUT_DEPTH + 1);

	stt_result_t      mem_q [OUT_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             rd;

	assign empty  = (cnt_q == '0);
	assign rd     = pop && !empty;
	assign result = mem_q[rd_ptr_q];
	// Room for the two tokens that one byte can cause.
	assign room   = (cnt_q <= CNT_W'(OUT_DEPTH - 2));

	// Storage: one or two entries written per cycle.
	always_ff @(posedge clk) begin
		if (wr_n != 2'd0) begin
			mem_q[wr_ptr_q] <= wr_data0;
		end
		if (wr_n == 2'd2) begin
			mem_q[wr_ptr_q + PTR_W'(1)] <= wr_data1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(wr_n);
			if (rd) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			cnt_q <= cnt_q + CNT_W'(wr_n) - CNT_W'(rd);
		end
	end

endmodule
